/* rtl/gclip_pkg.sv */
package gclip_pkg;

  // Default number of fractional bits of the Q formats.
  localparam int unsigned FracBitsDef = 16;

  // Request kinds.
  localparam logic ReqAccum = 1'b0;
  localparam logic ReqScale = 1'b1;

  // Result kinds.
  localparam logic KindNorm   = 1'b0;
  localparam logic KindScaled = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] grad_value;
    logic              last_element;
  } gclip_req_t;

  typedef struct packed {
    logic              result_kind;
    logic signed [31:0] scaled_value;
    logic [31:0]       norm_value;
    logic              clipped;
    logic              sum_saturated;
  } gclip_rsp_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StAcc  = 6'b000100,
    StSqrt = 6'b001000,
    StChk  = 6'b010000,
    StDiv  = 6'b100000
  } gclip_state_e;

endpackage

/* rtl/gradient_global_norm_clip_core.sv */
// Channel     Direction  Signals                         Handshake
// request     in         req_i (gclip_req_t)             start & !busy
// result      out        rsp_o (gclip_rsp_t)             rsp_valid_o, one cycle, no stall
// threshold   in         thr_i                           thr_we_i
//
// An accumulate request that does not end its pass, and every scale request, goes
// through capture, one shared 32x32 multiply, then accumulate or truncate-and-sign.
// One that ends a pass then takes the square root, 2 bits of the sum per cycle, and
// the threshold check, then, if the threshold is nonzero and below the norm, the
// division, 1 quotient bit per cycle; both run on one shared subtractor.
// Reset is asynchronous and active low; it clears the sum, the flags, the norm and
// the threshold and sets the scale to one. The receiver cannot stall results, so
// each result is shown for exactly one cycle while the next request may already start.
module gradient_global_norm_clip_core #(
  parameter int unsigned FracBits = gclip_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  gclip_pkg::gclip_req_t  req_i,
  output logic                   rsp_valid_o,
  output gclip_pkg::gclip_rsp_t  rsp_o,
  input  logic                   thr_we_i,
  input  logic [31:0]            thr_i
);
  import gclip_pkg::*;

  // The scale factor is at most one, so it needs one integer bit.
  localparam int unsigned ScaleW = FracBits + 1;
  localparam int unsigned CntW   = $clog2((FracBits > 32) ? FracBits : 32);
  localparam logic [ScaleW-1:0] ScaleOne = {1'b1, {FracBits{1'b0}}};
  localparam logic [CntW-1:0] SqrtLast = CntW'(31);
  localparam logic [CntW-1:0] DivLast  = CntW'(FracBits - 1);

  gclip_state_e state_q, state_d;

  // Captured request.
  logic        req_type_q;
  logic        last_q;
  logic        neg_q;
  logic [31:0] mag_q;

  // Arithmetic registers.
  logic [63:0]       prod_q;
  logic [63:0]       sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic [31:0]       norm_q, norm_d;
  logic [ScaleW-1:0] scale_q, scale_d;
  logic [32:0]       rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       thr_q;

  // Result register.
  logic       rsp_valid_q, rsp_valid_d;
  gclip_rsp_t rsp_q, rsp_d;

  logic        accept;
  logic [31:0] grad_mag;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [64:0] acc_sum;
  logic [63:0] acc_sat;
  logic [31:0] shifted;
  logic [35:0] sub_a, sub_b, sub_diff;
  logic        sub_ge;

  assign busy   = (state_q != StIdle);
  assign accept = start & ~busy;

  // Two's-complement magnitude; the most negative value maps to 2^31.
  assign grad_mag = req_i.grad_value[31] ? (~req_i.grad_value + 32'd1) : req_i.grad_value;

  // The one multiplier squares the element in an accumulate request and applies
  // the scale factor in a scale request.
  assign mul_b = (req_type_q == ReqScale) ? 32'(scale_q) : mag_q;
  assign mul_p = 64'(mag_q) * 64'(mul_b);

  // Saturating accumulation of the square.
  assign acc_sum = {1'b0, sum_q} + {1'b0, prod_q};
  assign acc_sat = acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];

  // Drop the fractional bits of the product, which truncates the magnitude.
  assign shifted = prod_q[FracBits +: 32];

  // Shared subtractor. The square root brings in the next two bits of the sum
  // and tries root*4+1; the division doubles the remainder and tries the norm.
  always_comb begin
    if (state_q == StSqrt) begin
      sub_a = {1'b0, rem_q, sum_q[63:62]};
      sub_b = {2'b00, norm_q, 2'b01};
    end else begin
      sub_a = {2'b00, rem_q, 1'b0};
      sub_b = {4'b0000, norm_q};
    end
  end
  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = ~sub_diff[35];

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    norm_d      = norm_q;
    scale_d     = scale_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StAcc;
      end
      StAcc: begin
        if (req_type_q == ReqScale) begin
          rsp_valid_d         = 1'b1;
          rsp_d.result_kind   = KindScaled;
          rsp_d.scaled_value  = neg_q ? (32'd0 - shifted) : shifted;
          rsp_d.norm_value    = norm_q;
          rsp_d.clipped       = ~scale_q[FracBits];
          rsp_d.sum_saturated = 1'b0;
          state_d             = StIdle;
        end else begin
          sum_d = acc_sat;
          if (acc_sum[64]) begin
            ovf_d = 1'b1;
          end
          if (last_q) begin
            // Start the root from scratch; the sum is consumed two bits a cycle
            // and is therefore zero again once the root is done.
            norm_d  = '0;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = StSqrt;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StSqrt: begin
        sum_d  = {sum_q[61:0], 2'b00};
        norm_d = {norm_q[30:0], sub_ge};
        rem_d  = sub_ge ? sub_diff[32:0] : sub_a[32:0];
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == SqrtLast) begin
          state_d = StChk;
        end
      end
      StChk: begin
        if ((thr_q != 32'd0) && (norm_q > thr_q)) begin
          // The quotient of the threshold by a larger norm is below one, so only
          // the fractional bits need to be produced.
          rem_d   = {1'b0, thr_q};
          scale_d = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          scale_d             = ScaleOne;
          rsp_valid_d         = 1'b1;
          rsp_d.result_kind   = KindNorm;
          rsp_d.scaled_value  = '0;
          rsp_d.norm_value    = norm_q;
          rsp_d.clipped       = 1'b0;
          rsp_d.sum_saturated = ovf_q;
          ovf_d               = 1'b0;
          state_d             = StIdle;
        end
      end
      StDiv: begin
        scale_d = {scale_q[FracBits-1:0], sub_ge};
        rem_d   = sub_ge ? sub_diff[32:0] : sub_a[32:0];
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == DivLast) begin
          rsp_valid_d         = 1'b1;
          rsp_d.result_kind   = KindNorm;
          rsp_d.scaled_value  = '0;
          rsp_d.norm_value    = norm_q;
          rsp_d.clipped       = 1'b1;
          rsp_d.sum_saturated = ovf_q;
          ovf_d               = 1'b0;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      norm_q      <= '0;
      scale_q     <= ScaleOne;
      thr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      norm_q      <= norm_d;
      scale_q     <= scale_d;
      rsp_valid_q <= rsp_valid_d;
      if (thr_we_i) begin
        thr_q <= thr_i;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      last_q     <= req_i.last_element;
      neg_q      <= req_i.grad_value[31];
      mag_q      <= grad_mag;
    end
    if (state_q == StMul) begin
      prod_q <= mul_p;
    end
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
